// ===== design/triangle_min_path_sum_core_defines.svh =====
// ----------------------------------------------------------------------------
// triangle min path sum assertion macros
// shared assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MIN_PATH_SUM_CORE_DEFINES_SVH
`define TRIANGLE_MIN_PATH_SUM_CORE_DEFINES_SVH

// checked outside reset
`define TMPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TMPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tmps_pkg.sv =====
// ----------------------------------------------------------------------------
// tmps_pkg
// widths and shared types of the triangle minimum path sum block
// ----------------------------------------------------------------------------
package tmps_pkg;

  localparam int VAL_W = 16;
  localparam int SUM_W = 24;
  localparam int CFG_W = 9;

  typedef struct packed {
    logic first_row;
    logic left_edge;
    logic right_edge;
    logic last_row;
    logic emit;
  } tmps_slot_t;

endpackage

// ===== design/triangle_min_path_sum_core.sv =====
// ----------------------------------------------------------------------------
// triangle_min_path_sum_core
// minimum apex to bottom path sum of a number triangle
// ----------------------------------------------------------------------------
// entry words arrive row by row, top row first, on entry_valid/entry_ready;
// row r carries r+1 words. the row count is set on the cfg channel, by the
// user between triangles; the block does not enforce this. one min_sum word
// leaves on sum_valid/sum_ready after the last entry of the last row, via
// the s1 stage and the output register. throughput is one entry per cycle,
// but the last entry of a triangle waits while the output register holds an
// earlier result or is about to be loaded. each entry does one read of the
// row sum ram, one add and compare, and one write back the following cycle;
// a write and a read of the same column in one cycle are forwarded. a result
// held by a stalled receiver does not block other entries.
// reset clears the counters, the row count to one and the output valid;
// the ram needs no clearing since each column is written before it is read.
// ----------------------------------------------------------------------------
module triangle_min_path_sum_core #(
  parameter int MAX_ROWS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tmps_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              entry_valid,
  output logic                              entry_ready,
  input  logic signed [tmps_pkg::VAL_W-1:0] entry_value,
  output logic                              sum_valid,
  input  logic                              sum_ready,
  output logic signed [tmps_pkg::SUM_W-1:0] min_sum
);
  import tmps_pkg::*;

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic                    accept;
  logic [IDX_W-1:0]        col;
  tmps_slot_t              slot;

  logic                    s1_valid;
  tmps_slot_t              s1_slot;
  logic [IDX_W-1:0]        s1_col;
  logic signed [VAL_W-1:0] s1_value;
  logic                    s1_fwd;
  logic signed [SUM_W-1:0] fwd_data;
  logic signed [SUM_W-1:0] rd_data;
  logic signed [SUM_W-1:0] parent_b;
  logic signed [SUM_W-1:0] left_parent_sum;
  logic signed [SUM_W-1:0] bottom_row_min;
  logic signed [SUM_W-1:0] bottom_min_next;
  logic signed [SUM_W-1:0] parent;
  logic signed [SUM_W-1:0] sum;

  assign cfg_ready = 1'b1;

  tmps_seq #(
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .entry_valid (entry_valid),
    .entry_ready (entry_ready),
    .s1_emit     (s1_valid && s1_slot.emit),
    .out_busy    (sum_valid && !sum_ready),
    .accept      (accept),
    .col         (col),
    .slot        (slot)
  );

  tmps_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (sum),
    .re    (accept),
    .raddr (col),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot  <= slot;
      s1_col   <= col;
      s1_value <= entry_value;
      s1_fwd   <= s1_valid && (s1_col == col);
      fwd_data <= sum;
    end
  end

  // old sum of this column, with a same-cycle write forwarded
  assign parent_b = s1_fwd ? fwd_data : rd_data;

  always_comb begin
    if (s1_slot.first_row) begin
      parent = '0;
    end else if (s1_slot.left_edge) begin
      parent = parent_b;
    end else if (s1_slot.right_edge) begin
      parent = left_parent_sum;
    end else if (left_parent_sum < parent_b) begin
      parent = left_parent_sum;
    end else begin
      parent = parent_b;
    end
    sum = SUM_W'(s1_value) + parent;
    bottom_min_next = bottom_row_min;
    if (s1_slot.last_row && (s1_slot.left_edge || sum < bottom_row_min)) begin
      bottom_min_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_parent_sum <= '0;
      bottom_row_min  <= '0;
    end else if (s1_valid) begin
      left_parent_sum <= s1_slot.emit ? '0 : parent_b;
      bottom_row_min  <= bottom_min_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (s1_valid && s1_slot.emit) begin
      sum_valid <= 1'b1;
    end else if (sum_ready) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_slot.emit) begin
      min_sum <= bottom_min_next;
    end
  end

endmodule

// ===== design/tmps_ram.sv =====
// ----------------------------------------------------------------------------
// tmps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tmps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tmps_seq.sv =====
// ----------------------------------------------------------------------------
// tmps_seq
// row and column counters, row count register and input flow control
// ----------------------------------------------------------------------------
module tmps_seq #(
  parameter int MAX_ROWS = 256
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           cfg_valid,
  input  logic [tmps_pkg::CFG_W-1:0]                     cfg_data,
  input  logic                                           entry_valid,
  output logic                                           entry_ready,
  input  logic                                           s1_emit,
  input  logic                                           out_busy,
  output logic                                           accept,
  output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] col,
  output tmps_pkg::tmps_slot_t                           slot
);
  import tmps_pkg::*;

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [CFG_W-1:0] row_count;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] column_index;
  logic [31:0]      rows_req;
  logic [31:0]      rows_eff;
  logic [31:0]      row_plus;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CFG_W'(1);
    end else if (cfg_valid) begin
      row_count <= cfg_data;
    end
  end

  // zero counts as one row, large counts saturate
  always_comb begin
    rows_req = {{(32-CFG_W){1'b0}}, row_count};
    rows_eff = rows_req;
    if (rows_req == 32'd0) begin
      rows_eff = 32'd1;
    end else if (rows_req > 32'(MAX_ROWS)) begin
      rows_eff = 32'(MAX_ROWS);
    end
    row_plus = {{(32-IDX_W){1'b0}}, row_index} + 32'd1;
  end

  always_comb begin
    slot.first_row  = (row_index == '0);
    slot.left_edge  = (column_index == '0);
    slot.right_edge = (column_index == row_index);
    slot.last_row   = (row_plus >= rows_eff);
    slot.emit       = slot.right_edge && slot.last_row;
  end

  // a word that ends a triangle waits until the output slot is sure to be free
  assign entry_ready = !(slot.emit && (s1_emit || out_busy));
  assign accept      = entry_valid && entry_ready;
  assign col         = column_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= '0;
      column_index <= '0;
    end else if (accept) begin
      if (slot.right_edge) begin
        column_index <= '0;
        if (slot.last_row) begin
          row_index <= '0;
        end else begin
          row_index <= row_index + IDX_W'(1);
        end
      end else begin
        column_index <= column_index + IDX_W'(1);
      end
    end
  end

endmodule

// ===== design/tmps_checker.sv =====
// ----------------------------------------------------------------------------
// tmps_checker
// port level checks of the triangle minimum path sum block
// ----------------------------------------------------------------------------
`include "triangle_min_path_sum_core_defines.svh"

module tmps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              entry_valid,
  input logic                              entry_ready,
  input logic                              sum_valid,
  input logic                              sum_ready,
  input logic signed [tmps_pkg::SUM_W-1:0] min_sum
);

  // a stalled result word holds
  `TMPS_ASSERT(a_sum_hold, sum_valid && !sum_ready |=> sum_valid && $stable(min_sum), "result word changed while stalled")

  // reset empties the output register
  `TMPS_ASSERT_ALWAYS(a_rst_clear, rst |=> !sum_valid, "result valid after reset")

  // a new result follows an earlier accepted entry word
  `TMPS_ASSERT(a_sum_cause, $rose(sum_valid) |-> $past(entry_valid && entry_ready, 2), "result without an entry word")

  // entry stalls only while a result waits or is in flight
  `TMPS_ASSERT(a_ready_why, !entry_ready |-> sum_valid || $past(entry_valid && entry_ready), "entry stalled with no result pending")

endmodule

bind triangle_min_path_sum_core tmps_checker u_tmps_checker (.*);
